[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/swa_pkg.sv]
package swa_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;

	localparam int POS_W  = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + POS_W;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int STEP_W = $clog2(SUM_W + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic [POS_W-1:0]              pos_t;

endpackage

[hw/rtl/swa_if.sv]
interface swa_sample_if;
	import swa_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface swa_average_if;
	import swa_pkg::*;

	logic    valid;
	logic    ready;
	sample_t average;

	modport source(output valid, output average, input ready);
	modport sink(input valid, input average, output ready);
endinterface

[hw/rtl/swa_ring.sv]
// History ring: one write port, one registered read port.
module swa_ring (
	input  logic             clk,
	input  logic             we,
	input  swa_pkg::pos_t    waddr,
	input  swa_pkg::sample_t wdata,
	input  logic             re,
	input  swa_pkg::pos_t    raddr,
	output swa_pkg::sample_t rdata
);
	import swa_pkg::*;

	sample_t mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/swa_div.sv]
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle, truncates toward zero.
module swa_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  swa_pkg::sum_t    dividend,
	input  swa_pkg::cnt_t    divisor,
	output logic             done,
	output swa_pkg::sample_t quotient
);
	import swa_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

	dstate_t             state_q;
	logic [STEP_W-1:0]   step_q;
	logic [SUM_W-1:0]    quo_q;
	cnt_t                rem_q;
	cnt_t                den_q;
	logic                neg_q;
	logic [CNT_W:0]      shifted;
	logic [CNT_W:0]      trial;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= D_IDLE;
			step_q   <= '0;
			quo_q    <= '0;
			rem_q    <= '0;
			den_q    <= '0;
			neg_q    <= 1'b0;
			done     <= 1'b0;
			quotient <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= dividend[SUM_W-1];
						quo_q   <= dividend[SUM_W-1] ? $unsigned(-dividend)
						                             : $unsigned(dividend);
						rem_q   <= '0;
						den_q   <= divisor;
						step_q  <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					// no borrow: shifted remainder covers the divisor
					if (!trial[CNT_W]) begin
						rem_q <= trial[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					quotient <= neg_q ? -sample_t'(quo_q[SAMPLE_BITS-1:0])
					                  : sample_t'(quo_q[SAMPLE_BITS-1:0]);
					done     <= 1'b1;
					state_q  <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	`ASSERT_PROP(a_rem_below_den, clk, arst_n, (state_q == D_RUN) |-> (rem_q < den_q), "remainder not below divisor")
	`ASSERT_PROP(a_step_range, clk, arst_n, (state_q == D_RUN) |-> (step_q < STEP_W'(SUM_W)), "step count overran")
	`ASSERT_PROP(a_done_after_fix, clk, arst_n, done |-> $past(state_q == D_FIX), "done without sign fix")

endmodule

[hw/rtl/sliding_window_average_unit.sv]
// From sample transaction to average valid: ring read, accumulate with divider load,
//   22 divide steps, sign fix, output register.
// No new sample is taken until the bit-serial divider over the 22-bit sum has finished the last one.
// A result held in the output register stalls the next one in the divider, and
//   sample ready stays low until the output frees up.
// Reset (arst_n low, asynchronous): window 64, sum, position and count zero.
module sliding_window_average_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  swa_pkg::cnt_t        wr_data,
	swa_sample_if.sink           sample_bus,
	swa_average_if.source        average_bus
);
	import swa_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_ACCUM, ST_DIVIDE, ST_HOLD} state_t;

	state_t  state_q;
	cnt_t    win_q;      // active window length, 1..MAX_WINDOW
	cnt_t    count_q;    // samples seen since clear, saturates at win_q
	pos_t    pos_q;      // ring slot of the oldest sample
	sum_t    sum_q;      // exact sum of live ring entries
	sample_t smp_q;      // sample under work
	diff_t   diff_q;     // new sample minus evicted one
	logic    out_valid_q;
	sample_t avg_q;

	logic    accept;
	logic    out_free;
	logic    load_out;
	sample_t ring_rdata;
	sample_t old_smp;
	cnt_t    pos_inc;
	cnt_t    win_clamped;
	sum_t    sum_next;
	logic    div_start;
	logic    div_done;
	sample_t div_quot;

	assign sample_bus.ready  = (state_q == ST_IDLE);
	assign accept            = sample_bus.valid && sample_bus.ready;
	assign average_bus.valid = out_valid_q;
	assign average_bus.average = avg_q;
	assign out_free          = !out_valid_q || average_bus.ready;

	// quotient moves to the output register once the divider is done and the slot is free
	assign load_out = out_free &&
		(((state_q == ST_DIVIDE) && div_done) || (state_q == ST_HOLD));

	// During warm-up the write slot equals the count and was never filled
	// since the last clear, so it is taken as zero in place of the ring read data.
	assign old_smp = (count_q < win_q) ? '0 : ring_rdata;

	assign pos_inc  = cnt_t'(pos_q) + 1'b1;
	assign sum_next = sum_q + sum_t'(diff_q);
	assign div_start = (state_q == ST_ACCUM);

	always_comb begin
		priority if (wr_data == '0) begin
			win_clamped = cnt_t'(1);
		end else if (wr_data > cnt_t'(MAX_WINDOW)) begin
			win_clamped = cnt_t'(MAX_WINDOW);
		end else begin
			win_clamped = wr_data;
		end
	end

	swa_ring u_ring (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (pos_q),
		.wdata (smp_q),
		.re    (accept),
		.raddr (pos_q),
		.rdata (ring_rdata)
	);

	swa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= cnt_t'(MAX_WINDOW);
			count_q     <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			smp_q       <= '0;
			diff_q      <= '0;
			out_valid_q <= 1'b0;
			avg_q       <= '0;
		end else begin
			if (load_out) begin
				avg_q       <= div_quot;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && average_bus.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						smp_q   <= sample_bus.sample;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// ring slot is overwritten this cycle; step position and count
					diff_q  <= diff_t'(smp_q) - diff_t'(old_smp);
					pos_q   <= (pos_inc == win_q) ? '0 : pos_inc[POS_W-1:0];
					if (count_q < win_q) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					sum_q   <= sum_next;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					// quotient stays in the divider until the output frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// window write clears the filter
			if (wr_en) begin
				win_q   <= win_clamped;
				sum_q   <= '0;
				pos_q   <= '0;
				count_q <= '0;
			end
		end
	end

	`ASSERT_PROP(a_count_le_win, clk, arst_n, count_q <= win_q, "sample count above window")
	`ASSERT_PROP(a_pos_in_win, clk, arst_n, cnt_t'(pos_q) < win_q, "ring position outside window")
	`ASSERT_PROP(a_warmup_pos, clk, arst_n, (count_q < win_q) |-> (cnt_t'(pos_q) == count_q), "warm-up position does not track count")
	`ASSERT_NEVER(a_done_in_divide, clk, arst_n, div_done && (state_q != ST_DIVIDE), "divider finished outside divide state")

endmodule

[tb/sv/sliding_window_average_unit_tb.sv]
module sliding_window_average_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swa_pkg::*;

	localparam int GAP_MAX        = 10;    // per-transaction idle draw, both sides
	localparam int SETTLE_CYCLES  = 40;    // quiet stretch after a drain, a margin over the block latency
	localparam int HOLD_CYCLES    = 300;   // long receiver back-pressure stretch
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
	localparam int RANDOM_SAMPLES = 1150;
	localparam int SAMPLE_MAX     = 32767;
	localparam int SAMPLE_MIN     = -32768;

	// What the sender does next: offer a sample, load a new window length,
	// or just wait until every outstanding average has come back.
	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_WINDOW,
		OP_DRAIN
	} stim_op_e;

	typedef struct {
		stim_op_e op;
		int       value;
	} stim_t;

	// Content of one random run of samples.
	typedef enum logic [1:0] {
		FILL_UNIFORM,
		FILL_FLAT_EXTREME,
		FILL_NEAR_ZERO,
		FILL_MIXED_EXTREME
	} fill_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	cnt_t wr_data;

	swa_sample_if  sample_bus();
	swa_average_if average_bus();

	sliding_window_average_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_data     (wr_data),
		.sample_bus  (sample_bus),
		.average_bus (average_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stim_t   stim_q[$];       // pending sender work, filled up front
	sample_t average_q[$];    // averages still owed by the block, oldest first

	// Own copy of the filter state.
	sample_t history[MAX_WINDOW];
	longint  window_sum;
	int      write_slot;
	int      fill_count;
	int      window_len;

	int error_count;
	int samples_sent;
	int averages_seen;
	int idle_cycles;
	int tx_gap;
	int rx_gap;
	int rx_hold;
	int settle_count;

	// Window write: clamp to 1..MAX_WINDOW and clear the filter, as the block does.
	function automatic void load_window(cnt_t value);
		if (value < 1)
			window_len = 1;
		else if (value > MAX_WINDOW)
			window_len = MAX_WINDOW;
		else
			window_len = int'(value);
		foreach (history[i])
			history[i] = '0;
		window_sum = 0;
		write_slot = 0;
		fill_count = 0;
	endfunction

	// One sample in, one mean out. Count saturates at the window length so the
	// warm-up means are exact; signed division truncates toward zero.
	function automatic sample_t next_average(sample_t s);
		longint mean;
		window_sum = window_sum - history[write_slot] + s;
		history[write_slot] = s;
		write_slot = (write_slot + 1 >= window_len) ? 0 : write_slot + 1;
		if (fill_count < window_len)
			fill_count++;
		mean = window_sum / fill_count;
		return sample_t'(mean);
	endfunction

	// Idle draw with periodic stretches of back-to-back traffic.
	function automatic int draw_gap(int count, int period);
		if ((count / period) % 4 == 3)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	function automatic void push_stim(stim_op_e op, int value);
		stim_t item;
		item.op    = op;
		item.value = value;
		stim_q.push_back(item);
	endfunction

	// Sender. The prediction is taken at the edge where the sample transaction
	// completes. Window writes and pauses wait for the block to drain, then
	// for the latency margin, so a write never lands on work in flight.
	always @(posedge clk) begin : sample_driver
		logic    next_valid;
		sample_t next_sample;
		logic    next_wr;
		if (!arst_n) begin
			sample_bus.valid  <= 1'b0;
			sample_bus.sample <= '0;
			wr_en             <= 1'b0;
			wr_data           <= '0;
		end else begin
			next_valid  = sample_bus.valid;
			next_sample = sample_bus.sample;
			next_wr     = 1'b0;
			if (sample_bus.valid && sample_bus.ready) begin
				average_q.push_back(next_average(sample_bus.sample));
				samples_sent++;
				next_valid = 1'b0;
				tx_gap     = draw_gap(samples_sent, 150);
			end
			if (!next_valid && stim_q.size() > 0) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else begin
					case (stim_q[0].op)
						OP_SAMPLE: begin
							next_valid  = 1'b1;
							next_sample = sample_t'(stim_q[0].value);
							void'(stim_q.pop_front());
						end
						default: begin
							if (average_q.size() == 0 && !wr_en)
								settle_count++;
							else
								settle_count = 0;
							if (settle_count >= SETTLE_CYCLES) begin
								if (stim_q[0].op == OP_WINDOW) begin
									next_wr = 1'b1;
									wr_data <= cnt_t'(stim_q[0].value);
									load_window(cnt_t'(stim_q[0].value));
								end
								settle_count = 0;
								void'(stim_q.pop_front());
							end
						end
					endcase
				end
			end
			sample_bus.valid  <= next_valid;
			sample_bus.sample <= next_sample;
			wr_en             <= next_wr;
		end
	end

	// Receiver and checker. Every average transaction is matched against the
	// oldest prediction; a transaction with nothing owed is an error too.
	// Twice in the run ready is held low for a long stretch so the block
	// backs up and stalls the sample channel.
	always @(posedge clk) begin : average_monitor
		if (!arst_n) begin
			average_bus.ready <= 1'b0;
		end else begin
			if (average_bus.valid && average_bus.ready) begin
				averages_seen++;
				if (average_q.size() == 0 || average_bus.average !== average_q[0]) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t average mismatch: expected %s, got %0d", $time,
							(average_q.size() > 0) ? $sformatf("%0d", average_q[0]) : "none",
							average_bus.average);
				end
				if (average_q.size() > 0)
					void'(average_q.pop_front());
				rx_gap = draw_gap(averages_seen, 110);
				if (averages_seen == 150 || averages_seen == 650)
					rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				average_bus.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				average_bus.ready <= 1'b0;
			end else begin
				average_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles since the last transaction on any port.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (sample_bus.valid && sample_bus.ready) ||
				(average_bus.valid && average_bus.ready) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : stimulus
		int    count;
		int    len;
		int    wsel;
		int    cur_len;
		int    flat;
		fill_e fill;

		load_window(cnt_t'(MAX_WINDOW));

		// Directed: zero clamps to a window of one, so the output follows the input.
		push_stim(OP_WINDOW, 0);
		push_stim(OP_SAMPLE, SAMPLE_MAX);
		push_stim(OP_SAMPLE, SAMPLE_MIN);
		push_stim(OP_SAMPLE, -1);
		push_stim(OP_SAMPLE, 0);
		// Window of two: extreme sums, then rounding of an odd negative total.
		push_stim(OP_WINDOW, 2);
		push_stim(OP_SAMPLE, SAMPLE_MIN);
		push_stim(OP_SAMPLE, SAMPLE_MIN);
		push_stim(OP_SAMPLE, SAMPLE_MAX);
		push_stim(OP_SAMPLE, SAMPLE_MAX);
		push_stim(OP_SAMPLE, -1);
		// Window of three: warm-up means and truncation toward zero.
		push_stim(OP_WINDOW, 3);
		push_stim(OP_SAMPLE, 1);
		push_stim(OP_SAMPLE, -2);
		push_stim(OP_SAMPLE, -2);
		push_stim(OP_SAMPLE, 5);
		// Oversized write clamps to the maximum window; alternating bit patterns.
		push_stim(OP_WINDOW, 127);
		push_stim(OP_SAMPLE, 21845);
		push_stim(OP_SAMPLE, -21846);
		push_stim(OP_SAMPLE, SAMPLE_MAX);
		push_stim(OP_SAMPLE, SAMPLE_MIN);
		push_stim(OP_WINDOW, MAX_WINDOW);

		// Random phases: a window setting, then a run of samples whose length is
		// tied to the window so it wraps, sometimes several times.
		cur_len = MAX_WINDOW;
		count   = 0;
		while (count < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 7))
				0:       wsel = 0;
				1:       wsel = 1;
				2:       wsel = MAX_WINDOW;
				3:       wsel = MAX_WINDOW + 1;
				4:       wsel = 127;
				5:       wsel = $urandom_range(2, 8);
				default: wsel = $urandom_range(1, 127);
			endcase
			if ($urandom_range(0, 3) != 0) begin
				push_stim(OP_WINDOW, wsel);
				cur_len = (wsel < 1) ? 1 : (wsel > MAX_WINDOW) ? MAX_WINDOW : wsel;
			end else if ($urandom_range(0, 1) == 0) begin
				// keep the current window, but let the sender sit until drained
				push_stim(OP_DRAIN, 0);
			end
			len  = $urandom_range(1, 2 * cur_len + 4);
			fill = fill_e'($urandom_range(0, 3));
			flat = ($urandom_range(0, 1) == 0) ? SAMPLE_MAX : SAMPLE_MIN;
			for (int i = 0; i < len; i++) begin
				case (fill)
					FILL_UNIFORM:       push_stim(OP_SAMPLE, $urandom_range(0, 65535));
					FILL_FLAT_EXTREME:  push_stim(OP_SAMPLE, flat);
					FILL_NEAR_ZERO:     push_stim(OP_SAMPLE, $urandom_range(0, 8) - 4);
					FILL_MIXED_EXTREME: push_stim(OP_SAMPLE,
						($urandom_range(0, 1) == 0) ? SAMPLE_MAX : SAMPLE_MIN);
				endcase
			end
			count += len;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the queue to empty and every owed average to arrive.
		while (!(stim_q.size() == 0 && !sample_bus.valid && average_q.size() == 0) &&
				idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);

		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
		end else begin
			// Stray averages after the drain still count as errors.
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (error_count == 0)
				$display("PASS");
			else
				$display("FAIL");
		end
		$finish;
	end

endmodule
